@@ src/abtt_pkg.sv @@
// Shared constants, codes and types for the array binary tree traversal block.
`timescale 1ns / 1ps

package abtt_pkg;

    localparam int MAX_NODES = 63;
    localparam int MAX_DEPTH = 6;

    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 2;
    localparam int ORD_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int ADDR_W  = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int KEY_W   = $clog2(2 * MAX_NODES + 1);
    localparam int SP_W    = $clog2(MAX_DEPTH + 1);
    localparam int STK_W   = $clog2(MAX_DEPTH);

    localparam logic [BYTE_W-1:0] EMPTY_CODE_RESET = 8'd63;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 2'd0,
        CMD_TRAVERSE = 2'd1,
        CMD_CLEAR    = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [ORD_W-1:0] {
        ORD_PRE  = 2'd0,
        ORD_IN   = 2'd1,
        ORD_POST = 2'd2,
        ORD_ALT  = 2'd3
    } order_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORDER = 1'b0,
        REG_EMPTY = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALL,
        ST_CHECK,
        ST_RETURN,
        ST_FINISH
    } walk_state_t;

    // Control decoded from the walker state for one cycle.
    typedef struct packed {
        logic              rd_en;
        logic              push;
        logic              resume;
        logic              pop;
        logic              emit;
        logic              finish;
        logic [BYTE_W-1:0] emit_byte;
    } walk_ctl_t;

endpackage

@@ src/array_binary_tree_traversal.sv @@
// Heap-ordered binary tree store with a pre/in/post-order walker and result buffer.
`timescale 1ns / 1ps
// Loads and clears complete with no result; input stalls while walking. A traversal reaches
//   its first visit down the leftmost path; a pending byte holds it until the next visit.
// One walker step per cycle, held by result stalls: call, check, resume and pop per visited
//   node, call per out-of-range index, call and check per absent node, and return, finish to close.
// Reset: node count, stack pointer, walker state and valids clear at once; order resets to
//   preorder and the empty code to 63. Node memory has no reset and is read below the count.

module array_binary_tree_traversal
    import abtt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input transaction channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [BYTE_W-1:0]    node_byte,
    // result transaction channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    visited_byte,
    output logic                 last_of_run,
    output logic                 tree_empty,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ORD_W-1:0]  order_reg;
    logic [BYTE_W-1:0] empty_code_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg      <= ORD_PRE;
            empty_code_reg <= EMPTY_CODE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ORDER: order_reg      <= cfg_data[ORD_W-1:0];
                REG_EMPTY: empty_code_reg <= cfg_data;
            endcase
        end
    end

    // Order selector 3 walks as preorder.
    logic is_in;
    logic is_post;
    logic is_pre;
    assign is_in   = (order_t'(order_reg) == ORD_IN);
    assign is_post = (order_t'(order_reg) == ORD_POST);
    assign is_pre  = !is_in && !is_post;

    // ------------------------------------------------------------------
    // Walker state, node memory and frame stack
    // ------------------------------------------------------------------
    walk_state_t state_reg;
    walk_state_t state_next;
    walk_ctl_t   ctl;

    logic [KEY_W-1:0]  k_reg;        // node index of the current call
    logic [CNT_W-1:0]  count_reg;    // nodes loaded so far
    logic [SP_W-1:0]   sp_reg;       // frames on the stack

    logic [BYTE_W-1:0] node_mem [MAX_NODES];
    logic [BYTE_W-1:0] rd_data_reg;

    // One frame per tree level: node index, node byte, left-done flag.
    logic [ADDR_W-1:0] stk_idx   [MAX_DEPTH];
    logic [BYTE_W-1:0] stk_byte  [MAX_DEPTH];
    logic              stk_phase [MAX_DEPTH];

    logic [SP_W-1:0]   top_sp;
    logic [STK_W-1:0]  top_i;
    logic [STK_W-1:0]  push_i;
    assign top_sp = sp_reg - SP_W'(1);
    assign top_i  = top_sp[STK_W-1:0];
    assign push_i = sp_reg[STK_W-1:0];

    // One pending byte sits ahead of the output register so that the last
    // result of a run can be flagged once the walk ends.
    logic              pend_valid_reg;
    logic [BYTE_W-1:0] pend_byte_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_empty_reg;

    logic in_acc;
    logic out_free;
    logic can_emit;
    logic k_in_range;
    logic node_absent;

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_acc      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign can_emit    = !pend_valid_reg || out_free;
    assign k_in_range  = (k_reg < KEY_W'(count_reg));
    assign node_absent = (rd_data_reg == empty_code_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && (cmd_t'(command) == CMD_TRAVERSE))
                    state_next = ST_CALL;
            end
            ST_CALL:
            begin
                state_next = k_in_range ? ST_CHECK : ST_RETURN;
            end
            ST_CHECK:
            begin
                if (node_absent)
                    state_next = ST_RETURN;
                else if (ctl.push)
                    state_next = ST_CALL;
            end
            ST_RETURN:
            begin
                if (sp_reg == '0)
                    state_next = ST_FINISH;
                else if (ctl.resume)
                    state_next = ST_CALL;
            end
            ST_FINISH:
            begin
                if (ctl.finish)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Walker control: each step that emits waits for room in the result buffer.
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_CALL:
            begin
                ctl.rd_en = k_in_range;
            end
            ST_CHECK:
            begin
                ctl.emit_byte = rd_data_reg;
                if (!node_absent && (!is_pre || can_emit))
                begin
                    ctl.push = 1'b1;
                    ctl.emit = is_pre;
                end
            end
            ST_RETURN:
            begin
                ctl.emit_byte = stk_byte[top_i];
                if (sp_reg != '0)
                begin
                    if (!stk_phase[top_i])
                    begin
                        if (!is_in || can_emit)
                        begin
                            ctl.resume = 1'b1;
                            ctl.emit   = is_in;
                        end
                    end
                    else if (!is_post || can_emit)
                    begin
                        ctl.pop  = 1'b1;
                        ctl.emit = is_post;
                    end
                end
            end
            ST_FINISH:
            begin
                ctl.finish = out_free;
            end
            default: ctl = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Node count: advance on load into a non-full table, drop to zero on clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (in_acc)
        begin
            priority if (cmd_t'(command) == CMD_CLEAR)
                count_reg <= '0;
            else if ((cmd_t'(command) == CMD_LOAD) && (count_reg < CNT_W'(MAX_NODES)))
                count_reg <= count_reg + CNT_W'(1);
            else
                count_reg <= count_reg;
        end
    end

    // Node memory: write on load, registered read for the walker.
    always_ff @(posedge clk)
    begin
        if (in_acc && (cmd_t'(command) == CMD_LOAD) && (count_reg < CNT_W'(MAX_NODES)))
            node_mem[count_reg[ADDR_W-1:0]] <= node_byte;
        if (ctl.rd_en)
            rd_data_reg <= node_mem[k_reg[ADDR_W-1:0]];
    end

    // Current index: root on each accepted command, left child on push, right child on resume.
    always_ff @(posedge clk)
    begin
        priority if (in_acc)
            k_reg <= '0;
        else if (ctl.push)
            k_reg <= KEY_W'({k_reg[ADDR_W-1:0], 1'b1});
        else if (ctl.resume)
            k_reg <= KEY_W'({stk_idx[top_i], 1'b0}) + KEY_W'(2);
        else
            k_reg <= k_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= '0;
        else if (ctl.push)
            sp_reg <= sp_reg + SP_W'(1);
        else if (ctl.pop)
            sp_reg <= top_sp;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            stk_idx[push_i]   <= k_reg[ADDR_W-1:0];
            stk_byte[push_i]  <= rd_data_reg;
            stk_phase[push_i] <= 1'b0;
        end
        else if (ctl.resume)
            stk_phase[top_i] <= 1'b1;
    end

    // Result buffer: hold one byte back, push the previous one out on each emit,
    // flag the held byte as last when the walk finishes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctl.emit)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                    out_valid_reg <= 1'b1;
                else if (out_valid_reg && !out_stall)
                    out_valid_reg <= 1'b0;
            end
            else if (ctl.finish)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            pend_byte_reg <= ctl.emit_byte;
            if (pend_valid_reg)
            begin
                out_byte_reg  <= pend_byte_reg;
                out_last_reg  <= 1'b0;
                out_empty_reg <= 1'b0;
            end
        end
        else if (ctl.finish)
        begin
            out_byte_reg  <= pend_valid_reg ? pend_byte_reg : '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= !pend_valid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign visited_byte = out_byte_reg;
    assign last_of_run  = out_last_reg;
    assign tree_empty   = out_empty_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(MAX_DEPTH))
        else $error("walk stack overflow");

    a_idle_empty_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (sp_reg == '0) && !pend_valid_reg)
        else $error("walker idle with frames or a pending byte");

    a_finish_flags_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> out_valid_reg && out_last_reg)
        else $error("finished walk without a last result");

    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && pend_valid_reg) |-> out_free)
        else $error("result overwritten while stalled");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_NODES))
        else $error("node count past capacity");

endmodule
